/* design/jtpp_pkg.sv */
`timescale 1ns / 1ps
package jtpp_pkg;

   localparam int AXIS_W  = 2;
   localparam int DIST_W  = 32;
   localparam int VEL_W   = 32;
   localparam int ACC_W   = 32;
   localparam int COUNT_W = 31;
   localparam int PHASE_W = 32;
   localparam int CLK_W   = 27;
   localparam int CLKDIV_W = CLK_W + 3;
   localparam int ACC25_W = ACC_W + 5;

   // Shared divider and square root widths.
   localparam int NUM_W  = 66;
   localparam int DEN_W  = 43;
   localparam int RAD_W  = 110;
   localparam int ROOT_W = 55;
   localparam int SPEED_W = ROOT_W;

   localparam logic [CLK_W-1:0] STEP_CLK_RESET = 27'd100000;

   typedef enum logic [1:0] {
      SEG_ACCEL  = 2'd0,
      SEG_CRUISE = 2'd1,
      SEG_DECEL  = 2'd2
   } seg_type;

   typedef struct packed {
      logic [AXIS_W-1:0]  axis;
      logic               dir;
      logic [COUNT_W-1:0] dist_mag;
      logic [VEL_W-1:0]   vel;
      logic [ACC_W-1:0]   accel;
      logic [ACC25_W-1:0] accel25;
      logic               dist_zero;
      logic               accel_zero;
   } job_type;

endpackage

/* design/jtpp_req_if.sv */
`timescale 1ns / 1ps
interface jtpp_req_if;
   import jtpp_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [AXIS_W-1:0]        axis;
   logic signed [DIST_W-1:0] distance;
   logic [VEL_W-1:0]         jog_velocity;
   logic [ACC_W-1:0]         jog_accel;

   modport source (output valid, output axis, output distance, output jog_velocity,
                   output jog_accel, input ready);
   modport sink (input valid, input axis, input distance, input jog_velocity,
                 input jog_accel, output ready);
endinterface

/* design/jtpp_rsp_if.sv */
`timescale 1ns / 1ps
interface jtpp_rsp_if;
   import jtpp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [1:0]                segment;
   logic [AXIS_W-1:0]         axis_out;
   logic [COUNT_W-1:0]        step_count;
   logic                      direction;
   logic [PHASE_W-1:0]        phase_increment;
   logic signed [PHASE_W-1:0] increment_slope;
   logic                      last;

   modport source (output valid, output segment, output axis_out, output step_count,
                   output direction, output phase_increment, output increment_slope,
                   output last, input ready);
   modport sink (input valid, input segment, input axis_out, input step_count,
                 input direction, input phase_increment, input increment_slope,
                 input last, output ready);
endinterface

/* design/jog_trapezoid_profile_planner.sv */
`timescale 1ns / 1ps
// Jog profile planner: each request (axis, signed distance, Q24.8 velocity and
// acceleration) comes back as three results in order, accelerate, constant and
// decelerate, each with a step count, direction, DDS phase increment and slope.
// The planning time of a request, shortest with no ramp slopes to divide and
// longest for a full trapezoid, is set by the one shared divider that
// produces one quotient bit per cycle and runs up to five times per request
// (ramp length, two phase increments, two slopes; a short move uses the
// bit-serial square root in place of the ramp division). Two requests can
// wait in the input queue and one finished plan waits at the output while
// the next is planned. csr_wr_data sets the step clock in Hz (reset 100000,
// zero acts as one) and may only change while the block is idle.
module jog_trapezoid_profile_planner (
   input  logic                        clock,
   input  logic                        reset,
   jtpp_req_if.sink                    req_chan,
   jtpp_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [jtpp_pkg::CLK_W-1:0]  csr_wr_data
);
   import jtpp_pkg::*;

   logic [CLK_W-1:0]    step_clk_ff;
   logic [CLK_W-1:0]    step_clk_eff;
   logic [CLKDIV_W-1:0] clk_div;
   logic                q_full, q_push, q_pop, q_not_empty;
   job_type             push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_clk_ff <= STEP_CLK_RESET;
      end else if (csr_wr_en) begin
         step_clk_ff <= csr_wr_data;
      end
   end

   // Phase increment divisor is 5 * F; the remaining 2^24 is a shift.
   always_comb begin
      step_clk_eff = (step_clk_ff == '0) ? CLK_W'(1) : step_clk_ff;
      clk_div = {1'b0, step_clk_eff, 2'b0} + {3'b0, step_clk_eff};
   end

   jtpp_front u_front (
      .req_chan(req_chan), .full(q_full), .push(q_push), .job(push_job)
   );

   jtpp_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(push_job),
      .full(q_full), .pop(q_pop), .not_empty(q_not_empty), .pop_data(pop_job)
   );

   jtpp_back u_back (
      .clock(clock), .reset(reset), .q_not_empty(q_not_empty), .q_data(pop_job),
      .q_pop(q_pop), .clk_div(clk_div), .rsp_chan(rsp_chan)
   );
endmodule

/* design/jtpp_front.sv */
`timescale 1ns / 1ps
module jtpp_front (
   jtpp_req_if.sink           req_chan,
   input  logic               full,
   output logic               push,
   output jtpp_pkg::job_type  job
);
   import jtpp_pkg::*;

   logic [DIST_W-1:0] mag;

   assign req_chan.ready = !full;
   assign push = req_chan.valid && !full;

   always_comb begin
      mag = req_chan.distance[DIST_W-1] ? (~req_chan.distance + 32'd1)
                                        : req_chan.distance;
      job.axis = req_chan.axis;
      job.dir = req_chan.distance[DIST_W-1];
      // The most negative distance has no positive twin and saturates.
      job.dist_mag = mag[DIST_W-1] ? {COUNT_W{1'b1}} : mag[COUNT_W-1:0];
      job.vel = req_chan.jog_velocity;
      job.accel = req_chan.jog_accel;
      job.accel25 = {1'b0, req_chan.jog_accel, 4'b0} + {2'b0, req_chan.jog_accel, 3'b0}
                  + {5'b0, req_chan.jog_accel};
      job.dist_zero = (req_chan.distance == '0);
      job.accel_zero = (req_chan.jog_accel == '0);
   end
endmodule

/* design/jtpp_queue.sv */
`timescale 1ns / 1ps
module jtpp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  jtpp_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output jtpp_pkg::job_type pop_data
);
   import jtpp_pkg::*;

   job_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end
endmodule

/* design/jtpp_div.sv */
`timescale 1ns / 1ps
module jtpp_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [jtpp_pkg::NUM_W-1:0]   numer,
   input  logic [jtpp_pkg::DEN_W-1:0]   denom,
   output logic                         done,
   output logic [jtpp_pkg::NUM_W-1:0]   quot
);
   import jtpp_pkg::*;

   localparam logic [6:0] STEPS = 7'(NUM_W);

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             q_bit;

   assign done = done_ff;
   assign quot = num_ff;

   always_comb begin
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      q_bit = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numer;
         den_ff <= denom;
         rem_ff <= '0;
      end else if (busy_ff) begin
         // One quotient bit per cycle; quotient bits shift in behind the dividend.
         num_ff <= {num_ff[NUM_W-2:0], q_bit};
         rem_ff <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

/* design/jtpp_sqrt.sv */
`timescale 1ns / 1ps
module jtpp_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [jtpp_pkg::RAD_W-1:0]    radicand,
   output logic                          done,
   output logic [jtpp_pkg::ROOT_W-1:0]   root
);
   import jtpp_pkg::*;

   localparam int REM_W = ROOT_W + 4;
   localparam logic [5:0] STEPS = 6'(RAD_W / 2);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              fits;

   assign done = done_ff;
   assign root = root_ff;

   always_comb begin
      rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      trial = {2'b0, root_ff, 2'b01};
      fits = (rem_sh >= trial);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff <= radicand;
         rem_ff <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         // Two radicand bits in, one root bit out per cycle.
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff <= fits ? (rem_sh - trial) : rem_sh;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= STEPS;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

/* design/jtpp_back.sv */
`timescale 1ns / 1ps
module jtpp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_not_empty,
   input  jtpp_pkg::job_type               q_data,
   output logic                            q_pop,
   input  logic [jtpp_pkg::CLKDIV_W-1:0]   clk_div,
   jtpp_rsp_if.source                      rsp_chan
);
   import jtpp_pkg::*;

   typedef enum logic [18:0] {
      ST_IDLE     = 19'd1,
      ST_MUL_VV   = 19'd2,
      ST_MUL_NA   = 19'd4,
      ST_SUM3     = 19'd8,
      ST_SUM25    = 19'd16,
      ST_CLASS    = 19'd32,
      ST_DIV_CA   = 19'd64,
      ST_SQRT     = 19'd128,
      ST_PH_A     = 19'd256,
      ST_PH_A_W   = 19'd512,
      ST_PH_C     = 19'd1024,
      ST_PH_C_W   = 19'd2048,
      ST_SL_A     = 19'd4096,
      ST_SL_A_W   = 19'd8192,
      ST_MUL_SC   = 19'd16384,
      ST_MUL_SC_W = 19'd32768,
      ST_SL_D     = 19'd65536,
      ST_SL_D_W   = 19'd131072,
      ST_EMIT     = 19'd262144
   } state_type;

   function automatic logic [NUM_W-1:0] phase_num(input logic [SPEED_W-1:0] s);
      logic [SPEED_W+31:0] wide;
      wide = {s, 32'b0} - {32'b0, s};
      return {3'b0, wide[SPEED_W+31:24]};
   endfunction

   function automatic logic [PHASE_W-1:0] sat32(input logic [NUM_W-1:0] q);
      return (q[NUM_W-1:PHASE_W] != '0) ? {PHASE_W{1'b1}} : q[PHASE_W-1:0];
   endfunction

   function automatic logic [PHASE_W-1:0] mag33(input logic [PHASE_W:0] d);
      logic [PHASE_W:0] m;
      m = d[PHASE_W] ? (~d + 33'd1) : d;
      return m[PHASE_W-1:0];
   endfunction

   state_type state_ff, state_in;
   job_type   job_ff;

   logic [63:0]         prod_ff;
   logic [31:0]         mul_x, mul_y;
   logic [63:0]         vv_ff;
   logic [65:0]         ramp_ff;
   logic [62:0]         na_ff;
   logic [64:0]         na3_ff;
   logic [67:0]         na25_ff;
   logic [SPEED_W-1:0]  s_start_ff, s_cruise_ff;
   logic [COUNT_W-1:0]  ca_ff, cc_ff, cd_ff;
   logic [PHASE_W-1:0]  fa0_ff, fc0_ff, fa_ff, fc_ff, sa_ff, sd_ff;
   logic                div_neg_ff, div_neg_in;

   logic               div_start, div_done;
   logic [NUM_W-1:0]   div_numer, div_quot;
   logic [DEN_W-1:0]   div_denom;
   logic               sqrt_start, sqrt_done;
   logic [RAD_W-1:0]   sqrt_rad;
   logic [ROOT_W-1:0]  sqrt_root;

   logic               trap;
   logic [76:0]        rad_sum;
   logic [PHASE_W:0]   diff_a, diff_d;
   logic               cond_a, cond_d;
   logic [PHASE_W-1:0] slope_q;
   logic [PHASE_W-1:0] sa_fix;
   logic [SPEED_W-1:0] s_v, s_5v;

   // Emitter side: one finished plan waits here while the next is worked on.
   logic               emit_busy_ff;
   seg_type            seg_ff;
   logic [AXIS_W-1:0]  out_axis_ff;
   logic               out_dir_ff;
   logic [COUNT_W-1:0] out_ca_ff, out_cc_ff, out_cd_ff;
   logic [PHASE_W-1:0] out_fa_ff, out_fc_ff, out_fd_ff, out_sa_ff, out_sd_ff;

   jtpp_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_numer),
      .denom(div_denom), .done(div_done), .quot(div_quot)
   );

   jtpp_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sqrt_start), .radicand(sqrt_rad),
      .done(sqrt_done), .root(sqrt_root)
   );

   always_comb begin
      s_v = {7'b0, job_ff.vel, 16'b0};
      s_5v = {4'b0, ({3'b0, job_ff.vel} + {1'b0, job_ff.vel, 2'b0}), 16'b0};
      trap = ({7'b0, ramp_ff} < {na25_ff, 5'b0});
      rad_sum = {13'b0, vv_ff} + {1'b0, na25_ff, 8'b0};
      sqrt_rad = {1'b0, rad_sum, 32'b0};
      diff_a = {1'b0, fc0_ff} - {1'b0, fa0_ff};
      diff_d = {1'b0, fa0_ff} - {1'b0, fc_ff};
      cond_a = (fc0_ff != fa0_ff) && (ca_ff != '0);
      cond_d = (fc_ff != fa0_ff) && (cd_ff != '0);
      slope_q = div_neg_ff ? (~div_quot[PHASE_W-1:0] + 32'd1) : div_quot[PHASE_W-1:0];
      sa_fix = (slope_q == '0) ? 32'd1 : slope_q;
   end

   always_comb begin
      case (state_ff)
         ST_MUL_NA: begin
            mul_x = {1'b0, job_ff.dist_mag};
            mul_y = job_ff.accel;
         end
         ST_MUL_SC: begin
            mul_x = sa_ff;
            mul_y = {1'b0, ca_ff};
         end
         default: begin
            mul_x = job_ff.vel;
            mul_y = job_ff.vel;
         end
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_numer = '0;
      div_denom = '0;
      div_neg_in = div_neg_ff;
      sqrt_start = 1'b0;
      case (state_ff)
         ST_CLASS: begin
            if (!job_ff.dist_zero && !job_ff.accel_zero) begin
               if (trap) begin
                  div_start = 1'b1;
                  div_numer = ramp_ff;
                  div_denom = {job_ff.accel25, 6'b0};
               end else begin
                  sqrt_start = 1'b1;
               end
            end
         end
         ST_PH_A: begin
            div_start = 1'b1;
            div_numer = phase_num(s_start_ff);
            div_denom = {13'b0, clk_div};
         end
         ST_PH_C: begin
            div_start = 1'b1;
            div_numer = phase_num(s_cruise_ff);
            div_denom = {13'b0, clk_div};
         end
         ST_SL_A: begin
            div_start = cond_a;
            div_numer = {34'b0, mag33(diff_a)};
            div_denom = {12'b0, ca_ff};
            div_neg_in = diff_a[PHASE_W];
         end
         ST_SL_D: begin
            div_start = cond_d;
            div_numer = {34'b0, mag33(diff_d)};
            div_denom = {12'b0, cd_ff};
            div_neg_in = diff_d[PHASE_W];
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop = 1'b1;
               state_in = ST_MUL_VV;
            end
         end
         ST_MUL_VV: state_in = ST_MUL_NA;
         ST_MUL_NA: state_in = ST_SUM3;
         ST_SUM3:   state_in = ST_SUM25;
         ST_SUM25:  state_in = ST_CLASS;
         ST_CLASS: begin
            if (job_ff.dist_zero || job_ff.accel_zero) begin
               state_in = ST_PH_A;
            end else if (trap) begin
               state_in = ST_DIV_CA;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_DIV_CA: if (div_done) state_in = ST_PH_A;
         ST_SQRT:   if (sqrt_done) state_in = ST_PH_A;
         ST_PH_A:   state_in = ST_PH_A_W;
         ST_PH_A_W: if (div_done) state_in = ST_PH_C;
         ST_PH_C:   state_in = ST_PH_C_W;
         ST_PH_C_W: if (div_done) state_in = ST_SL_A;
         ST_SL_A:   state_in = cond_a ? ST_SL_A_W : ST_SL_D;
         ST_SL_A_W: if (div_done) state_in = ST_MUL_SC;
         ST_MUL_SC: state_in = ST_MUL_SC_W;
         ST_MUL_SC_W: state_in = ST_SL_D;
         ST_SL_D:   state_in = cond_d ? ST_SL_D_W : ST_EMIT;
         ST_SL_D_W: if (div_done) state_in = ST_EMIT;
         ST_EMIT:   if (!emit_busy_ff) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_x * mul_y;
      div_neg_ff <= div_neg_in;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               job_ff <= q_data;
            end
         end
         ST_MUL_NA: vv_ff <= prod_ff;
         ST_SUM3: begin
            na_ff <= prod_ff[62:0];
            na3_ff <= {2'b0, prod_ff[62:0]} + {1'b0, prod_ff[62:0], 1'b0};
            ramp_ff <= {2'b0, vv_ff} + {1'b0, vv_ff, 1'b0};
         end
         ST_SUM25: na25_ff <= {na3_ff, 3'b0} + {5'b0, na_ff};
         ST_CLASS: begin
            s_start_ff <= s_v;
            s_cruise_ff <= s_5v;
            if (job_ff.dist_zero) begin
               ca_ff <= '0;
               cc_ff <= '0;
               cd_ff <= '0;
            end else if (job_ff.accel_zero) begin
               // Without ramps every step runs at cruise speed from rest.
               s_start_ff <= '0;
               ca_ff <= '0;
               cc_ff <= job_ff.dist_mag;
               cd_ff <= '0;
            end else if (!trap) begin
               ca_ff <= {1'b0, job_ff.dist_mag[COUNT_W-1:1]};
               cc_ff <= '0;
               cd_ff <= job_ff.dist_mag - {1'b0, job_ff.dist_mag[COUNT_W-1:1]};
            end
         end
         ST_DIV_CA: begin
            if (div_done) begin
               ca_ff <= div_quot[COUNT_W-1:0];
               cd_ff <= div_quot[COUNT_W-1:0];
               cc_ff <= job_ff.dist_mag - {div_quot[COUNT_W-2:0], 1'b0};
            end
         end
         ST_SQRT: begin
            if (sqrt_done) begin
               s_cruise_ff <= sqrt_root;
            end
         end
         ST_PH_A_W: if (div_done) fa0_ff <= sat32(div_quot);
         ST_PH_C_W: if (div_done) fc0_ff <= sat32(div_quot);
         ST_SL_A: begin
            if (!cond_a) begin
               sa_ff <= '0;
               fa_ff <= fa0_ff;
               fc_ff <= fc0_ff;
            end
         end
         ST_SL_A_W: begin
            if (div_done) begin
               sa_ff <= sa_fix;
               fa_ff <= fa0_ff + sa_fix;
            end
         end
         ST_MUL_SC_W: fc_ff <= fa_ff + prod_ff[PHASE_W-1:0];
         ST_SL_D: if (!cond_d) sd_ff <= '0;
         ST_SL_D_W: if (div_done) sd_ff <= slope_q;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && !emit_busy_ff) begin
         out_axis_ff <= job_ff.axis;
         out_dir_ff <= job_ff.dir;
         out_ca_ff <= ca_ff;
         out_cc_ff <= cc_ff;
         out_cd_ff <= cd_ff;
         out_fa_ff <= fa_ff;
         out_fc_ff <= fc_ff;
         out_fd_ff <= fc0_ff;
         out_sa_ff <= sa_ff;
         out_sd_ff <= sd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         seg_ff <= SEG_ACCEL;
      end else if (state_ff == ST_EMIT && !emit_busy_ff) begin
         emit_busy_ff <= 1'b1;
         seg_ff <= SEG_ACCEL;
      end else if (emit_busy_ff && rsp_chan.ready) begin
         case (seg_ff)
            SEG_ACCEL:  seg_ff <= SEG_CRUISE;
            SEG_CRUISE: seg_ff <= SEG_DECEL;
            default: begin
               seg_ff <= SEG_ACCEL;
               emit_busy_ff <= 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_chan.valid = emit_busy_ff;
      rsp_chan.segment = seg_ff;
      rsp_chan.axis_out = out_axis_ff;
      rsp_chan.direction = out_dir_ff;
      rsp_chan.last = (seg_ff == SEG_DECEL);
      case (seg_ff)
         SEG_ACCEL: begin
            rsp_chan.step_count = out_ca_ff;
            rsp_chan.phase_increment = out_fa_ff;
            rsp_chan.increment_slope = out_sa_ff;
         end
         SEG_CRUISE: begin
            rsp_chan.step_count = out_cc_ff;
            rsp_chan.phase_increment = out_fc_ff;
            rsp_chan.increment_slope = '0;
         end
         default: begin
            rsp_chan.step_count = out_cd_ff;
            rsp_chan.phase_increment = out_fd_ff;
            rsp_chan.increment_slope = out_sd_ff;
         end
      endcase
   end
endmodule

/* dv/jog_trapezoid_profile_planner_checker.sv */
`timescale 1ns / 1ps
module jog_trapezoid_profile_planner_checker
   import jtpp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   jtpp_req_if              req_chan,
   jtpp_rsp_if              rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CLK_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               segments_pending
);

   typedef struct {
      seg_type            seg;
      logic [AXIS_W-1:0]  axis;
      logic [COUNT_W-1:0] steps;
      logic               dir;
      logic [31:0]        phase;
      logic [31:0]        slope;
      logic               last;
   } segment_type;

   segment_type       planned_segments[$];
   logic [CLK_W-1:0]  step_clk_hz;

   assign segments_pending = planned_segments.size();

   initial mismatch_count = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("%0t: mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
   endtask

   function automatic logic [31:0] dds_increment(input logic [127:0] speed,
                                                 input logic [127:0] f_hz);
      logic [127:0] q;
      q = (128'hFFFF_FFFF * speed) / (128'd1280 * 128'd65536 * f_hz);
      return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] ramp_slope(input logic [31:0] to_incr,
                                              input logic [31:0] from_incr,
                                              input logic [63:0] steps);
      longint diff;
      longint q;
      diff = longint'({32'b0, to_incr}) - longint'({32'b0, from_incr});
      q = diff / longint'(steps);
      return q[31:0];
   endfunction

   function automatic void plan_jog(input logic [AXIS_W-1:0] axis,
                                    input logic [31:0] jog_dist,
                                    input logic [31:0] vel,
                                    input logic [31:0] acc);
      logic         dir;
      logic [31:0]  n32;
      logic [127:0] n, v, a, f_hz, ramp, s_start, s_cruise, rad, root, cand;
      logic [63:0]  ca, cc, cd;
      logic [31:0]  fa, fe, fc, fdec, sa, sd;
      segment_type  s;
      dir = jog_dist[31];
      n32 = dir ? -jog_dist : jog_dist;
      if (n32 > 32'h7FFF_FFFF) begin
         n32 = 32'h7FFF_FFFF;
      end
      n = 128'(n32);
      v = 128'(vel);
      a = 128'(acc);
      f_hz = (step_clk_hz == 0) ? 128'd1 : 128'(step_clk_hz);
      s_start = v << 16;
      s_cruise = (v * 5) << 16;
      ca = 0;
      cc = 0;
      cd = 0;
      sa = 0;
      sd = 0;
      if (n != 0) begin
         if (a != 0) begin
            ramp = 3 * v * v;
            if (800 * n * a > ramp) begin
               ca = 64'(ramp / (1600 * a));
               cd = ca;
               cc = n[63:0] - 2 * ca;
            end else begin
               // Triangle: peak speed from the integer square root.
               ca = n[63:0] >> 1;
               cd = n[63:0] - ca;
               rad = (v * v + 6400 * n * a) << 32;
               root = 0;
               for (int b = 56; b >= 0; b--) begin
                  cand = root | (128'd1 << b);
                  if (cand * cand <= rad) begin
                     root = cand;
                  end
               end
               s_cruise = root;
            end
         end else begin
            s_start = 0;
            cc = n[63:0];
         end
      end
      fa = dds_increment(s_start, f_hz);
      fe = fa;
      fc = dds_increment(s_cruise, f_hz);
      fdec = fc;
      if (fc != fa && ca != 0) begin
         sa = ramp_slope(fc, fa, ca);
         if (sa == 0) begin
            sa = 1;
         end
         fa = fa + sa;
         fc = 32'(64'(fa) + 64'(sa) * ca);
      end
      if (fc != fe && cd != 0) begin
         sd = ramp_slope(fe, fc, cd);
      end
      s = '{SEG_ACCEL, axis, ca[30:0], dir, fa, sa, 1'b0};
      planned_segments.push_back(s);
      s = '{SEG_CRUISE, axis, cc[30:0], dir, fc, 32'd0, 1'b0};
      planned_segments.push_back(s);
      s = '{SEG_DECEL, axis, cd[30:0], dir, fdec, sd, 1'b1};
      planned_segments.push_back(s);
   endfunction

   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         step_clk_hz <= STEP_CLK_RESET;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            plan_jog(req_chan.axis, req_chan.distance, req_chan.jog_velocity,
                     req_chan.jog_accel);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (planned_segments.size() == 0) begin
               report_mismatch("unexpected segment", 32'(rsp_chan.segment), 32'd0);
            end else begin
               want = planned_segments.pop_front();
               if (rsp_chan.segment != want.seg)
                  report_mismatch("segment", 32'(rsp_chan.segment), 32'(want.seg));
               if (rsp_chan.axis_out != want.axis)
                  report_mismatch("axis_out", 32'(rsp_chan.axis_out), 32'(want.axis));
               if (rsp_chan.step_count != want.steps)
                  report_mismatch("step_count", 32'(rsp_chan.step_count), 32'(want.steps));
               if (rsp_chan.direction != want.dir)
                  report_mismatch("direction", 32'(rsp_chan.direction), 32'(want.dir));
               if (rsp_chan.phase_increment != want.phase)
                  report_mismatch("phase_increment", rsp_chan.phase_increment, want.phase);
               if (rsp_chan.increment_slope != want.slope)
                  report_mismatch("increment_slope", rsp_chan.increment_slope, want.slope);
               if (rsp_chan.last != want.last)
                  report_mismatch("last", 32'(rsp_chan.last), 32'(want.last));
            end
         end
         if (csr_wr_en) begin
            step_clk_hz <= csr_wr_data;
         end
      end
   end

endmodule

/* dv/jog_trapezoid_profile_planner_tb.sv */
`timescale 1ns / 1ps
module jog_trapezoid_profile_planner_tb;
   import jtpp_pkg::*;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [CLK_W-1:0] csr_wr_data;
   int               mismatch_count;
   int               segments_pending;
   int               hold_cycles;
   bit               gaps_on;
   int               jog_count;

   jtpp_req_if req_chan ();
   jtpp_rsp_if rsp_chan ();

   jog_trapezoid_profile_planner u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   jog_trapezoid_profile_planner_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .mismatch_count   (mismatch_count),
      .segments_pending (segments_pending)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Verification failed");
      $finish;
   end

   // The receiver stalls at random, or for a long hold when one is requested.
   initial begin
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 0;
            hold_cycles--;
         end else begin
            rsp_chan.ready <= !(gaps_on && $urandom_range(0, 99) < 37);
         end
      end
   end

   task automatic send_jog(input logic [1:0] axis, input logic [31:0] jog_dist,
                           input logic [31:0] vel, input logic [31:0] acc);
      if (gaps_on && $urandom_range(0, 99) < 37) begin
         req_chan.valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid        <= 1;
      req_chan.axis         <= axis;
      req_chan.distance     <= jog_dist;
      req_chan.jog_velocity <= vel;
      req_chan.jog_accel    <= acc;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      jog_count++;
   endtask

   // Lets the block drain, then waits for the given number of settle cycles.
   task automatic drain(input int settle);
      req_chan.valid <= 0;
      while (segments_pending != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic set_step_clock(input logic [CLK_W-1:0] hz);
      drain(400);
      csr_wr_en   <= 1;
      csr_wr_data <= hz;
      @(posedge clock);
      csr_wr_en   <= 0;
   endtask

   function automatic logic [31:0] spread32();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return $urandom;
         default: return $urandom >> $urandom_range(8, 31);
      endcase
   endfunction

   task automatic random_jogs(input int count);
      logic [31:0] jog_dist;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0:       jog_dist = $urandom;
            1, 2:    jog_dist = $urandom >> $urandom_range(0, 31);
            3:       jog_dist = -($urandom >> $urandom_range(0, 31));
            default: jog_dist = 32'($signed($urandom_range(0, 400)) - 200);
         endcase
         gaps_on = !(jog_count >= 100 && jog_count < 160);
         if (jog_count == 200) begin
            hold_cycles = 3000;
         end
         send_jog(2'($urandom_range(0, 3)), jog_dist, spread32(), spread32());
         if (jog_count == 260) begin
            drain(0);
         end
      end
   endtask

   initial begin
      reset                 = 1;
      csr_wr_en             = 0;
      csr_wr_data           = 0;
      req_chan.valid        = 0;
      req_chan.axis         = 0;
      req_chan.distance     = 0;
      req_chan.jog_velocity = 0;
      req_chan.jog_accel    = 0;
      hold_cycles           = 0;
      gaps_on               = 1;
      jog_count             = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_jog(0, 0, 32'd25600, 32'd25600);
      send_jog(1, 1, 32'd25600, 32'd25600);
      send_jog(2, -1, 32'd25600, 32'd25600);
      send_jog(3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_jog(0, 32'h8000_0000, 32'hFFFF_FFFF, 32'd1);
      send_jog(1, 1000, 32'd256000, 0);
      send_jog(2, -1000, 0, 32'd25600);
      send_jog(3, 100000, 32'd2560000, 32'd256000);
      send_jog(0, 50, 32'd2560000, 32'd256000);
      send_jog(1, -32'sd100000, 32'd2560000, 32'd256000);
      send_jog(2, 32'h7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      send_jog(3, 3, 32'hFFFF_FFFF, 32'd1);
      send_jog(0, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA);
      send_jog(1, 0, 0, 0);
      random_jogs(70);

      set_step_clock(1);
      random_jogs(60);
      set_step_clock(27'h7FF_FFFF);
      random_jogs(60);
      set_step_clock(0);
      random_jogs(40);
      set_step_clock(27'd100000000);
      random_jogs(60);
      set_step_clock(CLK_W'($urandom_range(1, 27'h7FF_FFFF)));
      random_jogs(50);

      req_chan.valid <= 0;
      for (int t = 0; t < 200000 && segments_pending != 0; t++) @(posedge clock);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && segments_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
